// File: sv/bgtvp_pkg.sv
// ============================================================================
// bgtvp_pkg
// Shared types and constants for the BGR to display pixel packer.
// ============================================================================
package bgtvp_pkg;

    // Fixed field widths
    localparam int OFFSET_W    = 26;
    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register reset values
    localparam logic [31:0] RED_BITS_RST     = 32'h00FF_0000;
    localparam logic [31:0] GREEN_BITS_RST   = 32'h0000_FF00;
    localparam logic [31:0] BLUE_BITS_RST    = 32'h0000_00FF;
    localparam logic [1:0]  PIXEL_FORMAT_RST = 2'd3;
    localparam logic        MSB_FIRST_RST    = 1'b0;
    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [14:0] LINE_STRIDE_RST  = 15'd2560;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED_BITS     = 3'd0,
        CFG_GREEN_BITS   = 3'd1,
        CFG_BLUE_BITS    = 3'd2,
        CFG_PIXEL_FORMAT = 3'd3,
        CFG_MSB_FIRST    = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6,
        CFG_LINE_STRIDE  = 3'd7
    } cfg_index_t;

    // Configuration register set
    typedef struct packed {
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [1:0]  pixel_format;
        logic        msb_first;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [14:0] line_stride;
    } cfg_t;

    // Input word
    typedef struct packed {
        logic [7:0] blue_byte;
        logic [7:0] green_byte;
        logic [7:0] red_byte;
    } pixel_in_t;

    // Output word
    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [WORD_W-1:0]   packed_bytes;
        logic [2:0]          byte_count;
        logic                image_done;
    } pixel_out_t;

    // Entry passed from the front end to the packing back end
    typedef struct packed {
        pixel_in_t           pixel;
        logic [OFFSET_W-1:0] byte_offset;
        logic                image_done;
    } queue_entry_t;

endpackage

// File: sv/bgr_to_visual_pixel_packer_top.sv
// An accepted word is stored in the queue and then in the output register, which raises m_valid.
// Throughput: one word per cycle while the queue is not full, set by the front end's
// position counters, which take one word per cycle; a two-entry queue and the output register
// let the input keep flowing while a finished word waits.
// Reset (aresetn, synchronous, active low) clears the counters, row base, queue
// and output, and loads the register defaults; no clearing pass is needed.
// ============================================================================
// bgr_to_visual_pixel_packer_top
// Converts BGR source words into packed display pixels with their byte
// offsets in a top-down destination image.
// ============================================================================
module bgr_to_visual_pixel_packer_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [bgtvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bgtvp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // Input words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bgtvp_pkg::pixel_in_t                  s_data,
    // Output words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bgtvp_pkg::pixel_out_t                 m_data
);

    bgtvp_pkg::cfg_t         cfg_reg, cfg_next;
    bgtvp_pkg::queue_entry_t front_entry, q_data;
    logic                    s_accept;
    logic                    q_full, q_empty, q_pop;

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (bgtvp_pkg::cfg_index_t'(cfg_index))
                bgtvp_pkg::CFG_RED_BITS:     cfg_next.red_bits     = cfg_wr_data;
                bgtvp_pkg::CFG_GREEN_BITS:   cfg_next.green_bits   = cfg_wr_data;
                bgtvp_pkg::CFG_BLUE_BITS:    cfg_next.blue_bits    = cfg_wr_data;
                bgtvp_pkg::CFG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_wr_data[1:0];
                bgtvp_pkg::CFG_MSB_FIRST:    cfg_next.msb_first    = cfg_wr_data[0];
                bgtvp_pkg::CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wr_data[12:0];
                bgtvp_pkg::CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wr_data[12:0];
                bgtvp_pkg::CFG_LINE_STRIDE:  cfg_next.line_stride  = cfg_wr_data[14:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_bits     <= bgtvp_pkg::RED_BITS_RST;
            cfg_reg.green_bits   <= bgtvp_pkg::GREEN_BITS_RST;
            cfg_reg.blue_bits    <= bgtvp_pkg::BLUE_BITS_RST;
            cfg_reg.pixel_format <= bgtvp_pkg::PIXEL_FORMAT_RST;
            cfg_reg.msb_first    <= bgtvp_pkg::MSB_FIRST_RST;
            cfg_reg.image_width  <= bgtvp_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height <= bgtvp_pkg::IMAGE_HEIGHT_RST;
            cfg_reg.line_stride  <= bgtvp_pkg::LINE_STRIDE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end takes a word whenever the queue has room.
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    bgtvp_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (s_accept),
        .pixel   (s_data),
        .entry   (front_entry)
    );

    bgtvp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (front_entry),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bgtvp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // The block is ready for a word right after reset.
    a_ready_after_reset: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // The back end never takes from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // A word is only written into the queue when it has room.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !q_full)
        else $error("queue written while full");
`endif

endmodule

// File: sv/bgtvp_front.sv
// ============================================================================
// bgtvp_front
// Position tracker: keeps column, row and row base and forms the byte
// offset and the end-of-image flag of each accepted word.
// ============================================================================
module bgtvp_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bgtvp_pkg::cfg_t          cfg,
    input  logic                     accept,
    input  bgtvp_pkg::pixel_in_t     pixel,
    output bgtvp_pkg::queue_entry_t  entry
);

    localparam int CNT_W  = $clog2(MAX_DIMENSION);
    localparam int DIM_W  = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;
    localparam int PROD_W = DIM_W + 15;
    localparam int OFS_W  = bgtvp_pkg::OFFSET_W;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [OFS_W-1:0] base_reg, base_next;

    logic [DIM_W-1:0]  width_raw, height_raw, width_c, height_c;
    logic [PROD_W-1:0] start_prod;
    logic [OFS_W-1:0]  base_eff, col_scaled, stride_ext;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic              image_start, row_end, image_end;

    // Clamp the image size to 1..MAX_DIMENSION.
    assign width_raw  = DIM_W'(cfg.image_width);
    assign height_raw = DIM_W'(cfg.image_height);

    always_comb begin
        if (width_raw == '0) begin
            width_c = DIM_W'(1);
        end else if (width_raw > DIM_W'(MAX_DIMENSION)) begin
            width_c = DIM_W'(MAX_DIMENSION);
        end else begin
            width_c = width_raw;
        end
        if (height_raw == '0) begin
            height_c = DIM_W'(1);
        end else if (height_raw > DIM_W'(MAX_DIMENSION)) begin
            height_c = DIM_W'(MAX_DIMENSION);
        end else begin
            height_c = height_raw;
        end
    end

    // The first row written is the bottom row of the top-down image.
    assign start_prod = PROD_W'(height_c - DIM_W'(1)) * PROD_W'(cfg.line_stride);
    assign stride_ext = OFS_W'(cfg.line_stride);

    assign image_start = (col_reg == '0) && (row_reg == '0);
    assign base_eff    = image_start ? start_prod[OFS_W-1:0] : base_reg;

    // Column times bytes per pixel, built from shifts and an add.
    always_comb begin
        case (cfg.pixel_format)
            2'd0:    col_scaled = OFS_W'(col_reg);
            2'd1:    col_scaled = OFS_W'(col_reg) << 1;
            2'd2:    col_scaled = OFS_W'(col_reg) + (OFS_W'(col_reg) << 1);
            2'd3:    col_scaled = OFS_W'(col_reg) << 2;
            default: col_scaled = OFS_W'(col_reg);
        endcase
    end

    // Counter advance and wrap at row and image end.
    assign col_inc   = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc   = DIM_W'(row_reg) + DIM_W'(1);
    assign row_end   = (col_inc >= width_c);
    assign image_end = row_end && (row_inc >= height_c);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (accept) begin
            base_next = base_eff;
            if (row_end) begin
                col_next  = '0;
                base_next = base_eff - stride_ext;
                row_next  = image_end ? '0 : row_inc[CNT_W-1:0];
            end else begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

    // Entry handed to the queue.
    assign entry.pixel       = pixel;
    assign entry.byte_offset = base_eff + col_scaled;
    assign entry.image_done  = image_end;

endmodule

// File: sv/bgtvp_queue.sv
// ============================================================================
// bgtvp_queue
// Two-entry queue between the position front end and the packing back end.
// ============================================================================
module bgtvp_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  bgtvp_pkg::queue_entry_t  push_data,
    input  logic                     pop,
    output bgtvp_pkg::queue_entry_t  pop_data,
    output logic                     full,
    output logic                     empty
);

    bgtvp_pkg::queue_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/bgtvp_back.sv
// ============================================================================
// bgtvp_back
// Packing back end: places the three channels in the display word, orders
// its bytes and holds the finished word in the output register.
// ============================================================================
module bgtvp_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bgtvp_pkg::cfg_t          cfg,
    input  logic                     q_empty,
    input  bgtvp_pkg::queue_entry_t  q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bgtvp_pkg::pixel_out_t    m_data
);

    localparam int WORD_W = bgtvp_pkg::WORD_W;

    logic [4:0] red_left_reg,   red_right_reg;
    logic [4:0] green_left_reg, green_right_reg;
    logic [4:0] blue_left_reg,  blue_right_reg;
    logic [4:0] red_left_next,   red_right_next;
    logic [4:0] green_left_next, green_right_next;
    logic [4:0] blue_left_next,  blue_right_next;

    logic [WORD_W-1:0]     word;
    logic [WORD_W-1:0]     packed_word;
    logic [2:0]            nbytes;
    logic                  out_valid_reg, out_valid_next;
    bgtvp_pkg::pixel_out_t out_reg;

    // Left and right shift of a channel from the top set bit of its mask.
    // An empty mask shifts the byte out entirely.
    function automatic logic [9:0] mask_shifts(input logic [31:0] mask);
        logic       found;
        logic [4:0] top;
        logic [4:0] left_amt;
        logic [4:0] right_amt;
        found = 1'b0;
        top   = '0;
        for (int i = 0; i < 32; i++) begin
            if (mask[i]) begin
                found = 1'b1;
                top   = 5'(i);
            end
        end
        if (!found) begin
            left_amt  = 5'd0;
            right_amt = 5'd8;
        end else if (top >= 5'd7) begin
            left_amt  = top - 5'd7;
            right_amt = 5'd0;
        end else begin
            left_amt  = 5'd0;
            right_amt = 5'd7 - top;
        end
        return {left_amt, right_amt};
    endfunction

    function automatic logic [31:0] place(input logic [7:0] chan, input logic [4:0] left_amt,
                                          input logic [4:0] right_amt, input logic [31:0] mask);
        logic [31:0] v;
        v = (32'(chan) << left_amt) >> right_amt;
        return v & mask;
    endfunction

    // Shift amounts are registered and follow the masks in the next cycle; the user must
    // change masks only while the block is idle, as the block does not enforce it.
    assign {red_left_next,   red_right_next}   = mask_shifts(cfg.red_bits);
    assign {green_left_next, green_right_next} = mask_shifts(cfg.green_bits);
    assign {blue_left_next,  blue_right_next}  = mask_shifts(cfg.blue_bits);

    always_ff @(posedge aclk) begin
        red_left_reg    <= red_left_next;
        red_right_reg   <= red_right_next;
        green_left_reg  <= green_left_next;
        green_right_reg <= green_right_next;
        blue_left_reg   <= blue_left_next;
        blue_right_reg  <= blue_right_next;
    end

    // Display word from the three channels.
    assign word = place(q_data.pixel.red_byte,   red_left_reg,   red_right_reg,   cfg.red_bits)
                | place(q_data.pixel.green_byte, green_left_reg, green_right_reg, cfg.green_bits)
                | place(q_data.pixel.blue_byte,  blue_left_reg,  blue_right_reg,  cfg.blue_bits);

    assign nbytes = 3'(cfg.pixel_format) + 3'd1;

    // Byte ordering; bytes beyond the pixel size stay zero.
    always_comb begin
        logic [1:0] sel;
        packed_word = '0;
        for (int i = 0; i < 4; i++) begin
            sel = cfg.msb_first ? 2'(nbytes - 3'(i) - 3'd1) : 2'(i);
            if (3'(i) < nbytes) begin
                packed_word[8*i +: 8] = word[{sel, 3'b000} +: 8];
            end
        end
    end

    // Output register: refill whenever it is empty or being taken.
    assign q_pop = !q_empty && (!out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg.byte_offset  <= q_data.byte_offset;
            out_reg.packed_bytes <= packed_word;
            out_reg.byte_count   <= nbytes;
            out_reg.image_done   <= q_data.image_done;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
